// File: design/md4_pkg.sv
// ----------------------------------------------------------------------------
// MD4 package
// Word types, hash constants and step schedule tables for the MD4 engine.
// ----------------------------------------------------------------------------
package md4_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } md4_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } md4_out_t;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [31:0] K_ROUND2 = 32'h5a827999;
    localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [5:0] STEP_LAST = 6'd47;

    localparam int BUF_WORDS = 16;

    localparam logic [1:0] ROUND_F = 2'd0;
    localparam logic [1:0] ROUND_G = 2'd1;
    localparam logic [1:0] ROUND_H = 2'd2;

    // Message word used by a step: in order, column-major, then bit-reversed.
    function automatic logic [3:0] md4_widx(input logic [5:0] step);
        logic [3:0] j;
        logic [3:0] idx;
        j = step[3:0];
        case (step[5:4])
            ROUND_F: idx = j;
            ROUND_G: idx = {j[1:0], j[3:2]};
            ROUND_H: idx = {j[0], j[1], j[2], j[3]};
            default: idx = j;
        endcase
        return idx;
    endfunction

    // Rotate amount per round and step position within a group of four.
    function automatic logic [4:0] md4_shift(input logic [1:0] round, input logic [1:0] sel);
        logic [4:0] s;
        case (round)
            ROUND_F:
            begin
                case (sel)
                    2'd0:    s = 5'd3;
                    2'd1:    s = 5'd7;
                    2'd2:    s = 5'd11;
                    default: s = 5'd19;
                endcase
            end
            ROUND_G:
            begin
                case (sel)
                    2'd0:    s = 5'd3;
                    2'd1:    s = 5'd5;
                    2'd2:    s = 5'd9;
                    default: s = 5'd13;
                endcase
            end
            default:
            begin
                case (sel)
                    2'd0:    s = 5'd3;
                    2'd1:    s = 5'd9;
                    2'd2:    s = 5'd11;
                    default: s = 5'd15;
                endcase
            end
        endcase
        return s;
    endfunction

endpackage

// File: design/md4_ram.sv
// ----------------------------------------------------------------------------
// MD4 generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module md4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/md4_round.sv
// ----------------------------------------------------------------------------
// MD4 step unit
// One compression step: round function, additions and left rotate.
// ----------------------------------------------------------------------------
module md4_round
    import md4_pkg::*;
(
    input  logic [5:0]  step,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] w,
    output logic [31:0] result
);

    logic [1:0]  round;
    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] sum;
    logic [4:0]  s;
    logic [5:0]  rsh;

    assign round = step[5:4];

    always_comb
    begin
        case (round)
            ROUND_F:
            begin
                f = (b & c) | (~b & d);
                k = '0;
            end
            ROUND_G:
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end
            default:
            begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
        endcase
    end

    assign sum    = a + f + w + k;
    assign s      = md4_shift(round, step[1:0]);
    assign rsh    = 6'd32 - {1'b0, s};
    assign result = (sum << s) | (sum >> rsh);

endmodule

// File: design/md4_message_digest_unit.sv
// ----------------------------------------------------------------------------
// MD4 message digest unit
// Streaming MD4 hash engine, one message byte per input word.
// ----------------------------------------------------------------------------
// Usage:
//   msg channel (valid/ready): cmd 0 absorbs data_byte, cmd 1 finishes the
//   message. digest channel (valid/ready): four words per finish, word_index
//   0..3, last_word set on the fourth.
//   The byte that completes a 64-byte block starts a compression (a read
//   setup state, 48 steps through the shared step unit, then the chaining
//   adds), during which msg_ready is low. Finish generates 9 to 72
//   padding/length bytes at one per cycle, pausing for the compression of
//   each completed block (one or two), then presents the digest words one
//   per cycle while the receiver takes them. The block buffer is a 16 x 32
//   RAM written a word at a time and read one word per step.
//   Reset restores the initial chaining words, clears the bit count and
//   leaves the buffer contents undefined; no clearing pass is needed.
//   When the receiver stalls, the digest register holds its word and the
//   sequencer waits; after the fourth word is loaded the chain is
//   reinitialized and msg_ready returns even if that word is still waiting.
// ----------------------------------------------------------------------------
module md4_message_digest_unit
    import md4_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     msg_valid,
    output logic     msg_ready,
    input  md4_in_t  msg,
    output logic     digest_valid,
    input  logic     digest_ready,
    output md4_out_t digest
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PAD  = 6'b000010,
        ST_LOAD = 6'b000100,
        ST_STEP = 6'b001000,
        ST_ADD  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    localparam int AW = $clog2(BUF_WORDS);

    state_t      state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [1:0]  out_idx_reg, out_idx_next;
    logic        dvalid_reg, dvalid_next;
    logic        pad_first_reg, pad_first_next;
    logic        len_phase_reg, len_phase_next;
    logic        fin_reg, fin_next;
    logic [63:0] bit_count_reg, bit_count_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];

    logic [31:0] v_reg [4];
    logic [31:0] v_next [4];
    logic [23:0] asm_reg, asm_next;
    logic [63:0] len_reg, len_next;
    md4_out_t    dout_reg, dout_next;

    logic [5:0]    pos;
    logic [7:0]    pad_byte;
    logic [7:0]    abs_byte;
    logic          absorb;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic [1:0]    t;
    logic [31:0]   step_result;
    logic [5:0]    step_inc;

    assign pos       = bit_count_reg[8:3];
    assign msg_ready = (state_reg == ST_IDLE);
    assign step_inc  = step_reg + 6'd1;
    assign t         = 2'd0 - step_reg[1:0];

    // Padding byte: marker first, zeros up to offset 56, then the length.
    always_comb
    begin
        if (pad_first_reg)
        begin
            pad_byte = PAD_BYTE;
        end
        else if (len_phase_reg || (pos == LEN_POS))
        begin
            pad_byte = len_reg[{pos[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = '0;
        end
    end

    assign abs_byte  = (state_reg == ST_PAD) ? pad_byte : msg.data_byte;
    assign ram_waddr = pos[5:2];
    assign ram_wdata = {abs_byte, asm_reg};

    md4_ram #(
        .WIDTH(32),
        .DEPTH(BUF_WORDS)
    ) u_buf (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    md4_round u_step (
        .step  (step_reg),
        .a     (v_reg[t]),
        .b     (v_reg[t + 2'd1]),
        .c     (v_reg[t + 2'd2]),
        .d     (v_reg[t + 2'd3]),
        .w     (ram_rdata),
        .result(step_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_idx_next   = out_idx_reg;
        dvalid_next    = dvalid_reg && !digest_ready;
        pad_first_next = pad_first_reg;
        len_phase_next = len_phase_reg;
        fin_next       = fin_reg;
        bit_count_next = bit_count_reg;
        chain_next     = chain_reg;
        v_next         = v_reg;
        asm_next       = asm_reg;
        len_next       = len_reg;
        dout_next      = dout_reg;
        absorb         = 1'b0;
        ram_we         = 1'b0;
        ram_raddr      = md4_widx(step_inc);

        case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg.cmd == CMD_FINISH)
                    begin
                        len_next       = bit_count_reg;
                        pad_first_next = 1'b1;
                        len_phase_next = 1'b0;
                        fin_next       = 1'b1;
                        state_next     = ST_PAD;
                    end
                    else
                    begin
                        absorb = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                absorb         = 1'b1;
                pad_first_next = 1'b0;
                if (!pad_first_reg && (pos == LEN_POS))
                begin
                    len_phase_next = 1'b1;
                end
            end
            ST_LOAD:
            begin
                ram_raddr  = md4_widx(6'd0);
                v_next     = chain_reg;
                step_next  = '0;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                v_next[t] = step_result;
                step_next = step_inc;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_phase_reg)
                begin
                    out_idx_next = '0;
                    state_next   = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (!dvalid_reg || digest_ready)
                begin
                    dvalid_next           = 1'b1;
                    dout_next.digest_word = chain_reg[out_idx_reg];
                    dout_next.word_index  = out_idx_reg;
                    dout_next.last_word   = (out_idx_reg == 2'd3);
                    out_idx_next          = out_idx_reg + 2'd1;
                    if (out_idx_reg == 2'd3)
                    begin
                        chain_next[0]  = INIT_A;
                        chain_next[1]  = INIT_B;
                        chain_next[2]  = INIT_C;
                        chain_next[3]  = INIT_D;
                        bit_count_next = '0;
                        fin_next       = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Store the byte: collect lanes 0..2, write the word on lane 3.
        if (absorb)
        begin
            bit_count_next = {bit_count_reg[63:3] + 61'd1, 3'b000};
            case (pos[1:0])
                2'd0:    asm_next[7:0]   = abs_byte;
                2'd1:    asm_next[15:8]  = abs_byte;
                2'd2:    asm_next[23:16] = abs_byte;
                default: ram_we          = 1'b1;
            endcase
            if (pos == LAST_POS)
            begin
                state_next = ST_LOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_idx_reg   <= '0;
            dvalid_reg    <= 1'b0;
            pad_first_reg <= 1'b0;
            len_phase_reg <= 1'b0;
            fin_reg       <= 1'b0;
            bit_count_reg <= '0;
            chain_reg[0]  <= INIT_A;
            chain_reg[1]  <= INIT_B;
            chain_reg[2]  <= INIT_C;
            chain_reg[3]  <= INIT_D;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_idx_reg   <= out_idx_next;
            dvalid_reg    <= dvalid_next;
            pad_first_reg <= pad_first_next;
            len_phase_reg <= len_phase_next;
            fin_reg       <= fin_next;
            bit_count_reg <= bit_count_next;
            chain_reg     <= chain_next;
        end
    end

    // Working registers and output payload: no reset needed.
    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        asm_reg  <= asm_next;
        len_reg  <= len_next;
        dout_reg <= dout_next;
    end

    assign digest_valid = dvalid_reg;
    assign digest       = dout_reg;

endmodule
